### hdl/bffa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types, command codes and helpers of the first-fit bitmap allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

    localparam int WORD_BITS    = 32;
    localparam int INDEX_WORDS  = 32;
    localparam int MAX_WORDS_DEF = 32;

    localparam logic [2:0] CMD_SET   = 3'd0;
    localparam logic [2:0] CMD_CLEAR = 3'd1;
    localparam logic [2:0] CMD_TEST  = 3'd2;
    localparam logic [2:0] CMD_FIND  = 3'd3;
    localparam logic [2:0] CMD_ALLOC = 3'd4;

    localparam logic [5:0]  WORDS_RESET = 6'd32;
    localparam logic [31:0] FULL_WORD   = 32'hFFFF_FFFF;

    // register index of words_in_use on the configuration port
    localparam logic [0:0] REG_WORDS_IN_USE = 1'b0;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture the accepted transaction
        logic start;    // decode, clear results, issue the bit read
        logic modify;   // read-modify-write or test of one bit
        logic scan;     // one word of the free-bit scan
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic bit_go;   // set, clear or test within range
        logic is_find;  // find or allocate
        logic hit;      // scanned word holds a free bit
        logic miss;     // every word in use scanned, none free
    } t_dp_status;

    // position of the lowest zero bit of a word
    function automatic logic [4:0] lowest_zero(input logic [31:0] word);
        logic [4:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!word[i]) begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

endpackage
`default_nettype wire

### hdl/bffa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_ctrl
// Sequencer of the allocator: decode, bit update, word scan and hand-off.
// ----------------------------------------------------------------------------
module bffa_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  wire                   i_out_free,
    input  bffa_pkg::t_dp_status  i_status,
    output bffa_pkg::t_dp_cmd     o_cmd,
    output logic                  o_in_stall,
    output logic                  o_publish
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_MODIFY = 5'b00100,
        S_SCAN   = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_publish = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.start = 1'b1;
                priority if (i_status.bit_go) begin
                    n_state = S_MODIFY;
                end else if (i_status.is_find) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MODIFY: begin
                o_cmd.modify = 1'b1;
                n_state      = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.hit || i_status.miss) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_publish = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

### hdl/bffa_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_datapath
// Bitmap memory with per-word valid bits, scan pipeline and result registers.
// ----------------------------------------------------------------------------
module bffa_datapath #(
    parameter int MAX_WORDS = bffa_pkg::MAX_WORDS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  bffa_pkg::t_dp_cmd     i_cmd,
    input  wire  [2:0]            i_command,
    input  wire  [9:0]            i_bit_index,
    input  wire  [5:0]            i_words_in_use,
    output bffa_pkg::t_dp_status  o_status,
    output logic                  o_found,
    output logic [9:0]            o_bit_out,
    output logic                  o_range_error
);

    localparam int DEPTH = (MAX_WORDS < bffa_pkg::INDEX_WORDS) ? MAX_WORDS
                                                                : bffa_pkg::INDEX_WORDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;

    logic [2:0]  r_command;
    logic [9:0]  r_bit_index;
    logic [5:0]  r_scan;
    logic        r_chk_v;
    logic [4:0]  r_chk_word;
    logic [31:0] r_rdata;
    logic        r_rd_valid;
    logic        r_found;
    logic [9:0]  r_bit_out;
    logic        r_range_error;

    logic [5:0]    active;
    logic [4:0]    idx_word;
    logic          idx_oor;
    logic          is_bitop;
    logic          is_find;
    logic [31:0]   word_eff;
    logic [4:0]    zero_pos;
    logic [31:0]   bit_mask;
    logic          hit;
    logic          miss;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    assign active   = (i_words_in_use > 6'(DEPTH)) ? 6'(DEPTH) : i_words_in_use;
    assign idx_word = r_bit_index[9:5];
    assign idx_oor  = ({1'b0, idx_word} >= active);
    assign is_bitop = (r_command == bffa_pkg::CMD_SET) || (r_command == bffa_pkg::CMD_CLEAR)
                   || (r_command == bffa_pkg::CMD_TEST);
    assign is_find  = (r_command == bffa_pkg::CMD_FIND) || (r_command == bffa_pkg::CMD_ALLOC);

    // a word never written reads as all free
    assign word_eff = r_rd_valid ? r_rdata : '0;
    assign zero_pos = bffa_pkg::lowest_zero(word_eff);
    assign bit_mask = 32'd1 << r_bit_index[4:0];
    assign hit      = r_chk_v && (word_eff != bffa_pkg::FULL_WORD);
    assign miss     = !hit && (r_scan >= active);

    assign o_status.bit_go  = is_bitop && !idx_oor;
    assign o_status.is_find = is_find;
    assign o_status.hit     = hit;
    assign o_status.miss    = miss;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = idx_word[AW-1:0];
        if (i_cmd.start) begin
            rd_en = is_bitop && !idx_oor;
        end else if (i_cmd.scan) begin
            rd_en   = (r_scan < active);
            rd_addr = r_scan[AW-1:0];
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_word[AW-1:0];
        wr_data = word_eff | bit_mask;
        if (i_cmd.modify) begin
            wr_en = (r_command == bffa_pkg::CMD_SET) || (r_command == bffa_pkg::CMD_CLEAR);
            if (r_command == bffa_pkg::CMD_CLEAR) begin
                wr_data = word_eff & ~bit_mask;
            end
        end else if (i_cmd.scan && hit && (r_command == bffa_pkg::CMD_ALLOC)) begin
            wr_en   = 1'b1;
            wr_addr = r_chk_word[AW-1:0];
            wr_data = word_eff | (32'd1 << zero_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_valid <= r_valid[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_v <= 1'b0;
            r_scan  <= '0;
        end else if (i_cmd.start) begin
            r_chk_v <= 1'b0;
            r_scan  <= '0;
        end else if (i_cmd.scan) begin
            // word read this cycle is checked in the next one
            r_chk_v <= rd_en;
            if (rd_en) begin
                r_scan <= r_scan + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command   <= i_command;
            r_bit_index <= i_bit_index;
        end
        if (i_cmd.scan) begin
            r_chk_word <= r_scan[4:0];
        end
        if (i_cmd.start) begin
            r_found       <= 1'b0;
            r_bit_out     <= '0;
            r_range_error <= is_bitop && idx_oor;
        end else if (i_cmd.modify) begin
            if (r_command == bffa_pkg::CMD_TEST) begin
                r_found <= word_eff[r_bit_index[4:0]];
            end
        end else if (i_cmd.scan && hit) begin
            r_found   <= 1'b1;
            r_bit_out <= {r_chk_word, zero_pos};
        end
    end

    assign o_found       = r_found;
    assign o_bit_out     = r_bit_out;
    assign o_range_error = r_range_error;

endmodule
`default_nettype wire

### hdl/bitmap_first_free_allocator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_top
// First-fit bitmap allocator with set, clear, test, find and allocate.
// ----------------------------------------------------------------------------
// One transaction is worked at a time. Set, clear and test of a bit within
// range pass from acceptance through the decode, modify and done states to the
// output register; unknown commands and out-of-range indexes skip the modify
// state. Find and allocate read one bitmap word per cycle through the single
// memory read port and check it in the following cycle, stopping at the first
// word with a free bit or after the last word in use. The input is accepted
// again once the result is written, so the next transaction can be accepted
// while the previous result still waits in the output register; a held
// output register stalls only the hand-off of the following result.
// The bitmap reads as all free after reset without a clearing pass.
module bitmap_first_free_allocator_top #(
    parameter int MAX_WORDS = bffa_pkg::MAX_WORDS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [2:0]  i_in_command,
    input  wire  [9:0]  i_in_bit_index,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_out_found,
    output logic [9:0]  o_out_bit_out,
    output logic        o_out_range_error,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    bffa_pkg::t_dp_cmd    dp_cmd;
    bffa_pkg::t_dp_status dp_status;

    logic [5:0] r_words_in_use;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       r_out_found;
    logic [9:0] r_out_bit_out;
    logic       r_out_range_error;

    logic       out_free;
    logic       publish;
    logic       res_found;
    logic [9:0] res_bit_out;
    logic       res_range_error;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words_in_use <= bffa_pkg::WORDS_RESET;
        end else if (cfg_wr && (paddr[2:2] == bffa_pkg::REG_WORDS_IN_USE)) begin
            r_words_in_use <= pwdata[5:0];
        end
    end

    assign prdata = (paddr[2:2] == bffa_pkg::REG_WORDS_IN_USE) ? {26'd0, r_words_in_use}
                                                                : 32'd0;

    assign out_free = !r_out_valid || !i_out_stall;

    bffa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall),
        .o_publish  (publish)
    );

    bffa_datapath #(
        .MAX_WORDS (MAX_WORDS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_command      (i_in_command),
        .i_bit_index    (i_in_bit_index),
        .i_words_in_use (r_words_in_use),
        .o_status       (dp_status),
        .o_found        (res_found),
        .o_bit_out      (res_bit_out),
        .o_range_error  (res_range_error)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (publish) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (publish) begin
            r_out_found       <= res_found;
            r_out_bit_out     <= res_bit_out;
            r_out_range_error <= res_range_error;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_found       = r_out_found;
    assign o_out_bit_out     = r_out_bit_out;
    assign o_out_range_error = r_out_range_error;

    // a range error never comes with a found bit
    a_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_found && o_out_range_error))
        else $error("range error reported together with found");

    // a nonzero position only comes from a successful search
    a_pos_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_bit_out != 10'd0)) |-> o_out_found)
        else $error("bit position reported without found");

    // one transaction at a time: busy right after acceptance
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second transaction accepted while busy");

    // no result is published while the output register is held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !publish)
        else $error("pending result overwritten");

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit bitmap allocator.
// ----------------------------------------------------------------------------
// Drives command transactions through the valid/stall input channel and
// mirrors the bitmap in a local model that predicts found, bit_out and
// range_error for every accepted transaction. Named tests cover reset state,
// exhausting a one-word map, zero and oversized word counts, long output
// back-pressure and randomized alloc/free traffic under several word counts
// and idle patterns. The word count register is written between phases only.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [2:0] CMD_RSVD_MID   = 3'd6;
    localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;
    localparam logic [2:0] ADDR_WORDS_IN_USE = {bffa_pkg::REG_WORDS_IN_USE, 2'b00};
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 40;   // beyond the longest scan

    typedef struct packed {
        logic       found;
        logic [9:0] bit_out;
        logic       range_error;
    } t_alloc_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_in_command = '0;
    logic [9:0]  i_in_bit_index = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_out_found;
    logic [9:0]  o_out_bit_out;
    logic        o_out_range_error;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bitmap_first_free_allocator_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_command     (i_in_command),
        .i_in_bit_index   (i_in_bit_index),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_found      (o_out_found),
        .o_out_bit_out    (o_out_bit_out),
        .o_out_range_error(o_out_range_error),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mirror of the allocator state
    logic [31:0]   bitmap_model [bffa_pkg::INDEX_WORDS];
    logic [5:0]    words_cfg;
    t_alloc_result expected_q [$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int grants         = 0;
    int map_full_hits  = 0;
    int range_hits     = 0;
    int word_settings  = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req_cycles = 0;
    int hold_req_id     = 0;

    function automatic int active_words();
        return (words_cfg > 6'(bffa_pkg::INDEX_WORDS)) ? bffa_pkg::INDEX_WORDS
                                                       : int'(words_cfg);
    endfunction

    function automatic t_alloc_result apply_bitmap_op(input logic [2:0] cmd,
                                                      input logic [9:0] idx);
        t_alloc_result res;
        int            n;
        logic          hit;
        res = '0;
        n   = active_words();
        hit = 1'b0;
        if (cmd == bffa_pkg::CMD_SET || cmd == bffa_pkg::CMD_CLEAR
            || cmd == bffa_pkg::CMD_TEST) begin
            if (int'(idx[9:5]) >= n) begin
                res.range_error = 1'b1;
                range_hits++;
            end else if (cmd == bffa_pkg::CMD_SET) begin
                bitmap_model[idx[9:5]][idx[4:0]] = 1'b1;
            end else if (cmd == bffa_pkg::CMD_CLEAR) begin
                bitmap_model[idx[9:5]][idx[4:0]] = 1'b0;
            end else begin
                res.found = bitmap_model[idx[9:5]][idx[4:0]];
            end
        end else if (cmd == bffa_pkg::CMD_FIND || cmd == bffa_pkg::CMD_ALLOC) begin
            for (int w = 0; w < n && !hit; w++) begin
                for (int b = 0; b < bffa_pkg::WORD_BITS && !hit; b++) begin
                    if (!bitmap_model[w][b]) begin
                        hit = 1'b1;
                        res.found = 1'b1;
                        res.bit_out = 10'(w * bffa_pkg::WORD_BITS + b);
                        if (cmd == bffa_pkg::CMD_ALLOC) begin
                            bitmap_model[w][b] = 1'b1;
                            grants++;
                        end
                    end
                end
            end
            if (!hit) begin
                map_full_hits++;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_val, $realtime);
        mismatch_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_alloc_result exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch("transaction with nothing outstanding", 1, 0);
            end else begin
                exp_res = expected_q.pop_front();
                if (o_out_found !== exp_res.found)
                    report_mismatch("found", o_out_found, exp_res.found);
                if (o_out_bit_out !== exp_res.bit_out)
                    report_mismatch("bit_out", o_out_bit_out, exp_res.bit_out);
                if (o_out_range_error !== exp_res.range_error)
                    report_mismatch("range_error", o_out_range_error, exp_res.range_error);
            end
        end
    end

    // receiver stall, with an optional long hold-off
    always @(posedge i_clk) begin
        int hold_left;
        int hold_seen_id;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left = 0;
            hold_seen_id = 0;
        end else begin
            if (hold_req_id != hold_seen_id) begin
                hold_seen_id = hold_req_id;
                hold_left = hold_req_cycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // called right after a rising edge; returns right after the accepting edge
    task automatic send_item(input logic [2:0] cmd, input logic [9:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_in_command   <= cmd;
        i_in_bit_index <= idx;
        do @(posedge i_clk); while (o_in_stall);
        expected_q.push_back(apply_bitmap_op(cmd, idx));
        items_sent++;
    endtask

    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_word_count(input logic [5:0] value);
        wait_quiet();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_WORDS_IN_USE;
        pwdata  <= {26'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        words_cfg = value;
        word_settings++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[5:0] !== words_cfg)
            report_mismatch("words_in_use readback", prdata[5:0], words_cfg);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random_item();
        int         r;
        int         span;
        logic [2:0] cmd;
        logic [9:0] idx;
        r    = $urandom_range(99);
        span = active_words() * bffa_pkg::WORD_BITS;
        if (span == 0 || $urandom_range(9) == 0)
            idx = 10'($urandom_range(1023));
        else
            idx = 10'($urandom_range(span - 1));
        if (r < 35)      cmd = bffa_pkg::CMD_ALLOC;
        else if (r < 55) cmd = bffa_pkg::CMD_CLEAR;
        else if (r < 70) cmd = bffa_pkg::CMD_SET;
        else if (r < 85) cmd = bffa_pkg::CMD_TEST;
        else if (r < 93) cmd = bffa_pkg::CMD_FIND;
        else if (r < 96) cmd = 3'($urandom_range(CMD_RSVD_LAST, CMD_RSVD_FIRST));
        else             cmd = 3'($urandom_range(7));
        send_item(cmd, idx);
    endtask

    task automatic test_reset_state();
        set_word_count(bffa_pkg::WORDS_RESET);
        send_item(bffa_pkg::CMD_FIND, 10'h3FF);
        send_item(bffa_pkg::CMD_ALLOC, 10'h2AA);
        send_item(bffa_pkg::CMD_ALLOC, 10'h155);
        send_item(bffa_pkg::CMD_TEST, 10'd0);
        send_item(bffa_pkg::CMD_TEST, 10'd2);
        send_item(bffa_pkg::CMD_SET, 10'd1023);
        send_item(bffa_pkg::CMD_TEST, 10'd1023);
        send_item(bffa_pkg::CMD_CLEAR, 10'd1023);
        send_item(bffa_pkg::CMD_TEST, 10'd1023);
        send_item(bffa_pkg::CMD_CLEAR, 10'd0);
        send_item(bffa_pkg::CMD_FIND, 10'd0);
        send_item(CMD_RSVD_FIRST, 10'h3FF);
        send_item(CMD_RSVD_MID, 10'h2AA);
        send_item(CMD_RSVD_LAST, 10'h155);
    endtask

    task automatic test_exhaust_small_map();
        int guard;
        guard = 0;
        set_word_count(6'd1);
        while (bitmap_model[0] != bffa_pkg::FULL_WORD && guard < 40) begin
            send_item(bffa_pkg::CMD_ALLOC, 10'($urandom_range(1023)));
            guard++;
        end
        // no free bit left in the only word
        send_item(bffa_pkg::CMD_ALLOC, 10'd0);
        send_item(bffa_pkg::CMD_FIND, 10'd0);
        send_item(bffa_pkg::CMD_TEST, 10'd32);
        send_item(bffa_pkg::CMD_SET, 10'd32);
        send_item(bffa_pkg::CMD_CLEAR, 10'd1023);
        send_item(bffa_pkg::CMD_TEST, 10'd31);
        set_word_count(6'd2);
        send_item(bffa_pkg::CMD_ALLOC, 10'd0);
        // shrinking keeps the upper word but hides it
        set_word_count(6'd1);
        send_item(bffa_pkg::CMD_FIND, 10'd0);
        send_item(bffa_pkg::CMD_TEST, 10'd32);
        send_item(bffa_pkg::CMD_CLEAR, 10'd17);
        send_item(bffa_pkg::CMD_ALLOC, 10'd0);
        set_word_count(6'd2);
        send_item(bffa_pkg::CMD_TEST, 10'd32);
    endtask

    task automatic test_zero_and_oversize_count();
        set_word_count(6'd0);
        send_item(bffa_pkg::CMD_SET, 10'd0);
        send_item(bffa_pkg::CMD_CLEAR, 10'd0);
        send_item(bffa_pkg::CMD_TEST, 10'd0);
        send_item(bffa_pkg::CMD_FIND, 10'd0);
        send_item(bffa_pkg::CMD_ALLOC, 10'd0);
        set_word_count(6'd63);
        send_item(bffa_pkg::CMD_SET, 10'd1023);
        send_item(bffa_pkg::CMD_TEST, 10'd1023);
        send_item(bffa_pkg::CMD_CLEAR, 10'd1023);
        send_item(bffa_pkg::CMD_FIND, 10'd0);
    endtask

    task automatic test_output_backpressure();
        wait_quiet();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_req_cycles = 200;
        hold_req_id++;
        repeat (16) send_random_item();
    endtask

    task automatic test_random_traffic(input int n_items);
        int left;
        int seg;
        int pick;
        left = n_items;
        while (left > 0) begin
            pick = $urandom_range(9);
            // mostly small maps so they fill up and scans go deep
            if (pick < 4)       set_word_count(6'($urandom_range(4, 1)));
            else if (pick < 6)  set_word_count(6'd32);
            else if (pick == 6) set_word_count(6'd1);
            else                set_word_count(6'($urandom_range(32, 1)));
            seg = $urandom_range(160, 60);
            if (seg > left) seg = left;
            repeat (seg) send_random_item();
            left -= seg;
        end
    endtask

    initial begin
        for (int w = 0; w < bffa_pkg::INDEX_WORDS; w++) bitmap_model[w] = '0;
        words_cfg = bffa_pkg::WORDS_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct  = 33;
        recv_stall_pct = 53;
        test_reset_state();
        test_exhaust_small_map();
        test_zero_and_oversize_count();
        test_random_traffic(650);

        wait_quiet();
        send_idle_pct  = 53;
        recv_stall_pct = 33;
        test_random_traffic(650);

        test_output_backpressure();
        wait_quiet();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(650);

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d transactions and %0d results over %0d word count settings",
                 items_sent, results_seen, word_settings);
        $display("%0d allocations granted, %0d scans with no free bit, %0d range errors",
                 grants, map_full_hits, range_hits);
        if (mismatch_count == 0 && expected_q.size() == 0) begin
            $display("bitmap_first_free_allocator_top regression: pass");
        end else begin
            $display("bitmap_first_free_allocator_top regression: fail");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d transactions outstanding", expected_q.size());
        $display("bitmap_first_free_allocator_top regression: fail");
        $finish;
    end

endmodule
